// ----- src/fdr_pkg.sv -----
`timescale 1ns / 1ps

package fdr_pkg;

    // Iteration counts of the three shift-subtract units
    localparam int unsigned DIV_T_STEPS = 28;
    localparam int unsigned SQRT_STEPS  = 16;
    localparam int unsigned RATIO_STEPS = 15;

    localparam logic [15:0]        ETA_ONE   = 16'd4096;
    localparam logic [15:0]        ETA_RESET = 16'd6101;
    localparam logic signed [15:0] COS_MAX   = 16'sd16384;
    localparam logic signed [15:0] COS_MIN   = -16'sd16384;
    localparam logic [14:0]        REFL_ONE  = 15'd16384;
    localparam logic [28:0]        Q28_ONE   = 29'h1000_0000;
    localparam logic [15:0]        TERM_ONE  = 16'd32768;

    // Per-item side information carried down the pipe
    typedef struct packed {
        logic        pos;
        logic        one;
        logic        tir;
        logic [15:0] negv;
        logic [14:0] c;
        logic [15:0] e;
    } t_side;

    typedef struct packed {
        logic [14:0] reflectance;
        logic [15:0] cos_transmitted;
        logic        total_internal;
    } t_result;

endpackage

// ----- src/fresnel_dielectric_reflectance_top.sv -----
`timescale 1ns / 1ps

// Unpolarised dielectric Fresnel reflectance.
// Input channel: i_valid / o_stall with i_cos_incident (signed Q2.14). A
// transfer happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_reflectance (unsigned Q1.14),
// o_cos_transmitted (signed Q2.14) and o_total_internal, one result per item.
// Relative index is written through i_cfg_we / i_cfg_wdata (unsigned Q4.12)
// and should only change while no item is in flight.
// Throughput: one item per cycle while o_stall is low, set by the fully
// pipelined 28-step division, 16-step square root and two 15-step ratio
// dividers, one step per stage.
// Reset (synchronous, active low) empties the pipe and loads index 6101.
// When the receiver stalls, the output register holds its result and a skid
// register catches the item leaving the pipe; with the skid full o_stall is
// raised and the whole pipe freezes, so nothing is lost or repeated.
module fresnel_dielectric_reflectance_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_cos_incident,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [14:0]          o_reflectance,
    output logic signed [15:0]   o_cos_transmitted,
    output logic                 o_total_internal
);
    import fdr_pkg::*;

    logic        en;
    logic [15:0] r_eta;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta <= ETA_RESET;
        end else if (i_cfg_we) begin
            r_eta <= i_cfg_wdata;
        end
    end

    // ---------------- stage A: clamp and classify ----------------
    logic signed [15:0] w_v, w_vneg;
    t_side              n_a_side, r_a_side;
    logic               r_a_valid;

    always_comb begin
        if (i_cos_incident > COS_MAX) begin
            w_v = COS_MAX;
        end else if (i_cos_incident < COS_MIN) begin
            w_v = COS_MIN;
        end else begin
            w_v = i_cos_incident;
        end
        w_vneg        = -w_v;
        n_a_side.pos  = (w_v > 16'sd0);
        n_a_side.one  = (r_eta == ETA_ONE);
        n_a_side.tir  = 1'b0;
        n_a_side.negv = w_vneg;
        n_a_side.c    = w_v[15] ? w_vneg[14:0] : w_v[14:0];
        n_a_side.e    = (r_eta == 16'd0) ? 16'd1 : r_eta;
    end

    // ---------------- stages B to D: squares, sin^2, test ----------------
    t_side       r_b_side, r_c_side, r_d_side;
    t_side       n_d_side;
    logic        r_b_valid, r_c_valid, r_d_valid;
    logic [28:0] r_b_cc, r_c_s2;
    logic [31:0] r_b_ee, r_c_ee;
    logic [35:0] r_c_den, r_d_den, r_d_num;
    logic [60:0] r_d_prod;
    logic        r_d_full;
    logic        w_d_tirp;

    assign w_d_tirp = ({7'b0, r_c_s2} >= r_c_den);

    // outside-case total reflection flag joins the side information
    always_comb begin
        n_d_side     = r_c_side;
        n_d_side.tir = r_c_side.pos & w_d_tirp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side     <= n_a_side;
            // B
            r_b_side     <= r_a_side;
            r_b_cc       <= 29'({14'b0, r_a_side.c} * {14'b0, r_a_side.c});
            r_b_ee       <= {16'b0, r_a_side.e} * {16'b0, r_a_side.e};
            // C
            r_c_side     <= r_b_side;
            r_c_s2       <= Q28_ONE - r_b_cc;
            r_c_ee       <= r_b_ee;
            r_c_den      <= {r_b_ee, 4'b0};
            // D: outside test and numerator, inside product
            r_d_side     <= n_d_side;
            r_d_den      <= r_c_den;
            r_d_num      <= r_c_den - {7'b0, r_c_s2};
            r_d_full     <= (r_c_s2 == 29'd0);
            r_d_prod     <= {32'b0, r_c_s2} * {29'b0, r_c_ee};
        end
    end

    // ---------------- division for t^2 (outside case) ----------------
    logic        r_dv_valid [0:DIV_T_STEPS];
    t_side       r_dv_side  [0:DIV_T_STEPS];
    logic [35:0] r_dv_rem   [0:DIV_T_STEPS];
    logic [35:0] r_dv_den   [0:DIV_T_STEPS];
    logic [27:0] r_dv_q     [0:DIV_T_STEPS];
    logic        r_dv_full  [0:DIV_T_STEPS];
    logic [28:0] r_dv_t2n   [0:DIV_T_STEPS];
    logic        n_dv_valid [0:DIV_T_STEPS];
    t_side       n_dv_side  [0:DIV_T_STEPS];
    logic [35:0] n_dv_rem   [0:DIV_T_STEPS];
    logic [35:0] n_dv_den   [0:DIV_T_STEPS];
    logic [27:0] n_dv_q     [0:DIV_T_STEPS];
    logic        n_dv_full  [0:DIV_T_STEPS];
    logic [28:0] n_dv_t2n   [0:DIV_T_STEPS];
    logic [36:0] w_dv_sh    [0:DIV_T_STEPS-1];
    logic        w_dv_ge    [0:DIV_T_STEPS-1];

    always_comb begin
        // entry: inside-case test and t^2 are settled here
        n_dv_valid[0]    = r_d_valid;
        n_dv_side[0]     = r_d_side;
        n_dv_side[0].tir = r_d_side.tir | (~r_d_side.pos & (|r_d_prod[60:52]));
        n_dv_rem[0]      = r_d_num;
        n_dv_den[0]      = r_d_den;
        n_dv_q[0]        = 28'd0;
        n_dv_full[0]     = r_d_full;
        n_dv_t2n[0]      = Q28_ONE - {1'b0, r_d_prod[51:24]};
        for (int k = 0; k < DIV_T_STEPS; k++) begin
            w_dv_sh[k]      = {r_dv_rem[k], 1'b0};
            w_dv_ge[k]      = (w_dv_sh[k] >= {1'b0, r_dv_den[k]});
            n_dv_valid[k+1] = r_dv_valid[k];
            n_dv_side[k+1]  = r_dv_side[k];
            n_dv_rem[k+1]   = w_dv_ge[k] ? 36'(w_dv_sh[k] - {1'b0, r_dv_den[k]})
                                         : w_dv_sh[k][35:0];
            n_dv_den[k+1]   = r_dv_den[k];
            n_dv_q[k+1]     = {r_dv_q[k][26:0], w_dv_ge[k]};
            n_dv_full[k+1]  = r_dv_full[k];
            n_dv_t2n[k+1]   = r_dv_t2n[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_T_STEPS; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k <= DIV_T_STEPS; k++) begin
                r_dv_valid[k] <= n_dv_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= DIV_T_STEPS; k++) begin
                r_dv_side[k] <= n_dv_side[k];
                r_dv_rem[k]  <= n_dv_rem[k];
                r_dv_den[k]  <= n_dv_den[k];
                r_dv_q[k]    <= n_dv_q[k];
                r_dv_full[k] <= n_dv_full[k];
                r_dv_t2n[k]  <= n_dv_t2n[k];
            end
        end
    end

    // ---------------- square root of t^2 ----------------
    logic        r_sq_valid [0:SQRT_STEPS];
    t_side       r_sq_side  [0:SQRT_STEPS];
    logic [28:0] r_sq_x     [0:SQRT_STEPS];
    logic [30:0] r_sq_r     [0:SQRT_STEPS];
    logic        n_sq_valid [0:SQRT_STEPS];
    t_side       n_sq_side  [0:SQRT_STEPS];
    logic [28:0] n_sq_x     [0:SQRT_STEPS];
    logic [30:0] n_sq_r     [0:SQRT_STEPS];
    logic [30:0] w_sq_bit   [0:SQRT_STEPS-1];
    logic [31:0] w_sq_sum   [0:SQRT_STEPS-1];
    logic        w_sq_ge    [0:SQRT_STEPS-1];
    t_side       w_f_side;

    always_comb begin
        // t^2 select: zero on total reflection, exact one when sin^2 is zero
        w_f_side      = r_dv_side[DIV_T_STEPS];
        n_sq_valid[0] = r_dv_valid[DIV_T_STEPS];
        n_sq_side[0]  = w_f_side;
        n_sq_r[0]     = 31'd0;
        if (w_f_side.tir) begin
            n_sq_x[0] = 29'd0;
        end else if (!w_f_side.pos) begin
            n_sq_x[0] = r_dv_t2n[DIV_T_STEPS];
        end else if (r_dv_full[DIV_T_STEPS]) begin
            n_sq_x[0] = Q28_ONE;
        end else begin
            n_sq_x[0] = {1'b0, r_dv_q[DIV_T_STEPS]};
        end
        for (int j = 0; j < SQRT_STEPS; j++) begin
            w_sq_bit[j]     = 31'd1 << (2 * (SQRT_STEPS - 1 - j));
            w_sq_sum[j]     = {1'b0, r_sq_r[j]} + {1'b0, w_sq_bit[j]};
            w_sq_ge[j]      = ({3'b0, r_sq_x[j]} >= w_sq_sum[j]);
            n_sq_valid[j+1] = r_sq_valid[j];
            n_sq_side[j+1]  = r_sq_side[j];
            if (w_sq_ge[j]) begin
                n_sq_x[j+1] = 29'({3'b0, r_sq_x[j]} - w_sq_sum[j]);
                n_sq_r[j+1] = (r_sq_r[j] >> 1) + w_sq_bit[j];
            end else begin
                n_sq_x[j+1] = r_sq_x[j];
                n_sq_r[j+1] = r_sq_r[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                r_sq_valid[j] <= 1'b0;
            end
        end else if (en) begin
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                r_sq_valid[j] <= n_sq_valid[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= SQRT_STEPS; j++) begin
                r_sq_side[j] <= n_sq_side[j];
                r_sq_x[j]    <= n_sq_x[j];
                r_sq_r[j]    <= n_sq_r[j];
            end
        end
    end

    // ---------------- stages G to I: Rs / Rp operands ----------------
    logic [14:0] w_t;
    t_side       r_g_side, r_h_side, r_i_side;
    logic        r_g_valid, r_h_valid, r_i_valid;
    logic [14:0] r_g_t, r_h_t, r_i_t;
    logic [30:0] r_g_et, r_g_ec;
    logic [30:0] w_h_c4, w_h_t4;
    logic [30:0] r_h_as, r_h_ds, r_h_ap, r_h_dp;
    logic [61:0] r_i_as2, r_i_ds2, r_i_ap2, r_i_dp2;

    assign w_t    = r_sq_r[SQRT_STEPS][14:0];
    assign w_h_c4 = {4'b0, r_g_side.c, 12'b0};
    assign w_h_t4 = {4'b0, r_g_t, 12'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= r_sq_valid[SQRT_STEPS];
            r_h_valid <= r_g_valid;
            r_i_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // G: e*t and e*c
            r_g_side <= r_sq_side[SQRT_STEPS];
            r_g_t    <= w_t;
            r_g_et   <= {15'b0, r_sq_side[SQRT_STEPS].e} * {16'b0, w_t};
            r_g_ec   <= {15'b0, r_sq_side[SQRT_STEPS].e} * {16'b0, r_sq_side[SQRT_STEPS].c};
            // H: magnitudes of differences and the sums
            r_h_side <= r_g_side;
            r_h_t    <= r_g_t;
            r_h_as   <= (w_h_c4 >= r_g_et) ? (w_h_c4 - r_g_et) : (r_g_et - w_h_c4);
            r_h_ds   <= w_h_c4 + r_g_et;
            r_h_ap   <= (r_g_ec >= w_h_t4) ? (r_g_ec - w_h_t4) : (w_h_t4 - r_g_ec);
            r_h_dp   <= r_g_ec + w_h_t4;
            // I: squares
            r_i_side <= r_h_side;
            r_i_t    <= r_h_t;
            r_i_as2  <= {31'b0, r_h_as} * {31'b0, r_h_as};
            r_i_ds2  <= {31'b0, r_h_ds} * {31'b0, r_h_ds};
            r_i_ap2  <= {31'b0, r_h_ap} * {31'b0, r_h_ap};
            r_i_dp2  <= {31'b0, r_h_dp} * {31'b0, r_h_dp};
        end
    end

    // ---------------- two Q15 ratio dividers (lane 0 Rs, lane 1 Rp) ----------
    logic        r_rt_valid [0:RATIO_STEPS];
    t_side       r_rt_side  [0:RATIO_STEPS];
    logic [14:0] r_rt_t     [0:RATIO_STEPS];
    logic [61:0] r_rt_rem   [0:RATIO_STEPS][0:1];
    logic [61:0] r_rt_den   [0:RATIO_STEPS][0:1];
    logic [14:0] r_rt_q     [0:RATIO_STEPS][0:1];
    logic        r_rt_full  [0:RATIO_STEPS][0:1];
    logic        n_rt_valid [0:RATIO_STEPS];
    t_side       n_rt_side  [0:RATIO_STEPS];
    logic [14:0] n_rt_t     [0:RATIO_STEPS];
    logic [61:0] n_rt_rem   [0:RATIO_STEPS][0:1];
    logic [61:0] n_rt_den   [0:RATIO_STEPS][0:1];
    logic [14:0] n_rt_q     [0:RATIO_STEPS][0:1];
    logic        n_rt_full  [0:RATIO_STEPS][0:1];
    logic [62:0] w_rt_sh    [0:RATIO_STEPS-1][0:1];
    logic        w_rt_ge    [0:RATIO_STEPS-1][0:1];

    always_comb begin
        n_rt_valid[0]   = r_i_valid;
        n_rt_side[0]    = r_i_side;
        n_rt_t[0]       = r_i_t;
        n_rt_rem[0][0]  = r_i_as2;
        n_rt_den[0][0]  = r_i_ds2;
        n_rt_rem[0][1]  = r_i_ap2;
        n_rt_den[0][1]  = r_i_dp2;
        n_rt_q[0][0]    = 15'd0;
        n_rt_q[0][1]    = 15'd0;
        // a ratio of one or more, or a zero denominator, saturates the term
        n_rt_full[0][0] = (r_i_ds2 == 62'd0) || (r_i_as2 >= r_i_ds2);
        n_rt_full[0][1] = (r_i_dp2 == 62'd0) || (r_i_ap2 >= r_i_dp2);
        for (int k = 0; k < RATIO_STEPS; k++) begin
            n_rt_valid[k+1] = r_rt_valid[k];
            n_rt_side[k+1]  = r_rt_side[k];
            n_rt_t[k+1]     = r_rt_t[k];
            for (int l = 0; l < 2; l++) begin
                w_rt_sh[k][l]     = {r_rt_rem[k][l], 1'b0};
                w_rt_ge[k][l]     = (w_rt_sh[k][l] >= {1'b0, r_rt_den[k][l]});
                n_rt_rem[k+1][l]  = w_rt_ge[k][l]
                                  ? 62'(w_rt_sh[k][l] - {1'b0, r_rt_den[k][l]})
                                  : w_rt_sh[k][l][61:0];
                n_rt_den[k+1][l]  = r_rt_den[k][l];
                n_rt_q[k+1][l]    = {r_rt_q[k][l][13:0], w_rt_ge[k][l]};
                n_rt_full[k+1][l] = r_rt_full[k][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= RATIO_STEPS; k++) begin
                r_rt_valid[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k <= RATIO_STEPS; k++) begin
                r_rt_valid[k] <= n_rt_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= RATIO_STEPS; k++) begin
                r_rt_side[k] <= n_rt_side[k];
                r_rt_t[k]    <= n_rt_t[k];
                for (int l = 0; l < 2; l++) begin
                    r_rt_rem[k][l]  <= n_rt_rem[k][l];
                    r_rt_den[k][l]  <= n_rt_den[k][l];
                    r_rt_q[k][l]    <= n_rt_q[k][l];
                    r_rt_full[k][l] <= n_rt_full[k][l];
                end
            end
        end
    end

    // ---------------- result assembly ----------------
    t_side       w_k_side;
    logic [15:0] w_term_s, w_term_p;
    logic [16:0] w_sum;
    logic [14:0] w_refl;
    logic [15:0] w_t16;
    t_result     w_res;
    logic        w_tail_valid;

    always_comb begin
        w_k_side = r_rt_side[RATIO_STEPS];
        w_term_s = r_rt_full[RATIO_STEPS][0] ? TERM_ONE : {1'b0, r_rt_q[RATIO_STEPS][0]};
        w_term_p = r_rt_full[RATIO_STEPS][1] ? TERM_ONE : {1'b0, r_rt_q[RATIO_STEPS][1]};
        w_sum    = {1'b0, w_term_s} + {1'b0, w_term_p};
        w_refl   = (w_sum[16:2] > REFL_ONE) ? REFL_ONE : w_sum[16:2];
        w_t16    = {1'b0, r_rt_t[RATIO_STEPS]};
        if (w_k_side.one) begin
            w_res.reflectance     = 15'd0;
            w_res.cos_transmitted = w_k_side.negv;
            w_res.total_internal  = 1'b0;
        end else if (w_k_side.tir) begin
            w_res.reflectance     = REFL_ONE;
            w_res.cos_transmitted = 16'd0;
            w_res.total_internal  = 1'b1;
        end else begin
            w_res.reflectance     = w_refl;
            w_res.cos_transmitted = w_k_side.pos ? (16'd0 - w_t16) : w_t16;
            w_res.total_internal  = 1'b0;
        end
    end

    assign w_tail_valid = r_rt_valid[RATIO_STEPS];

    // ---------------- output register and skid ----------------
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    assign en      = ~r_skid_valid;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out        <= w_res;
                r_out_valid  <= w_tail_valid;
            end
        end else if (en && w_tail_valid) begin
            // output held: catch the item leaving the pipe
            r_skid       <= w_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_reflectance     = r_out.reflectance;
    assign o_cos_transmitted = r_out.cos_transmitted;
    assign o_total_internal  = r_out.total_internal;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled while the output was free");

    a_tir_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_total_internal) |->
            (o_reflectance == REFL_ONE && o_cos_transmitted == 16'sd0))
        else $error("total reflection result malformed");

    a_refl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflectance <= REFL_ONE))
        else $error("reflectance above one");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_tail_valid) |=> w_tail_valid)
        else $error("pipe tail moved while frozen");

endmodule
